// ===== rtl/core/rld_pkg.sv =====
package rld_pkg;

   // Field widths fixed by the stream format.
   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned WORD_W  = 64;
   localparam int unsigned BYTES_W = WORD_W / BYTE_W;
   localparam int unsigned SIZE_W  = 4;
   localparam int unsigned CNT_W   = 3;
   localparam int unsigned RUNS_W  = 11;

   // Largest field size in bytes, and the hard limit on runs per list.
   localparam logic [SIZE_W-1:0] MAX_FIELD_SIZE = 4'd8;
   localparam logic [RUNS_W-1:0] MAX_RUNS       = 11'd1024;
   localparam logic [RUNS_W-1:0] RUN_CAP_RESET  = 11'd512;

   // Result status codes.
   typedef enum logic [1:0] {
      ST_RUN      = 2'd0,
      ST_END      = 2'd1,
      ST_BAD_SIZE = 2'd2,
      ST_TOO_MANY = 2'd3
   } status_type;

   // Decoder phase, one-hot.
   typedef enum logic [3:0] {
      PH_HEADER = 4'b0001,
      PH_LENGTH = 4'b0010,
      PH_OFFSET = 4'b0100,
      PH_IDLE   = 4'b1000
   } phase_type;

endpackage

// ===== rtl/core/run_list_decoder_top.sv =====
// A transferred byte is held in the input register and decoded as it moves on from there;
// any result it causes is loaded into the result register and presented on rsp_valid.
// Throughput: one byte per cycle while the result side does not stall; the rate is set by
// the single input register feeding the single result register.
// Reset (synchronous, active high) returns the decoder to expecting a header with cluster
// base and run count zero, empties both registers and sets run_capacity to 512.
module run_list_decoder_top
   import rld_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [RUNS_W-1:0]   csr_wr_data,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [BYTE_W-1:0]   req_data_byte,
   input  logic                req_list_start,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [1:0]          rsp_status,
   output logic [WORD_W-1:0]   rsp_run_length,
   output logic [WORD_W-1:0]   rsp_run_start,
   output logic                rsp_sparse,
   output logic [RUNS_W-1:0]   rsp_run_index
);

   // Configuration register.
   logic [RUNS_W-1:0] run_cap_ff;

   // Input register.
   logic              in_vld_ff, in_vld_in;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              in_start_ff;

   // Decoder state.
   phase_type         phase_ff, phase_in;
   logic [SIZE_W-1:0] len_size_ff, len_size_in;
   logic [SIZE_W-1:0] off_size_ff, off_size_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [WORD_W-1:0] len_acc_ff, len_acc_in;
   logic [WORD_W-1:0] delta_acc_ff, delta_acc_in;
   logic [WORD_W-1:0] base_ff, base_in;
   logic [RUNS_W-1:0] runs_ff, runs_in;

   // Result register.
   logic              out_vld_ff, out_vld_in;
   status_type        out_status_ff, out_status_in;
   logic [WORD_W-1:0] out_len_ff, out_len_in;
   logic [WORD_W-1:0] out_start_ff, out_start_in;
   logic              out_sparse_ff, out_sparse_in;
   logic [RUNS_W-1:0] out_index_ff, out_index_in;

   logic              proceed;
   logic              req_xfer;
   logic              emit;

   // The held byte moves on when the result register is free or being emptied.
   assign proceed   = in_vld_ff && (!out_vld_ff || !rsp_stall);
   assign req_stall = in_vld_ff && !proceed;
   assign req_xfer  = req_valid && !req_stall;

   always_comb begin
      in_vld_in = in_vld_ff;
      if (req_xfer) begin
         in_vld_in = 1'b1;
      end else if (proceed) begin
         in_vld_in = 1'b0;
      end
   end

   // Decode one byte.
   always_comb begin
      phase_type         ph;
      logic [WORD_W-1:0] base;
      logic [RUNS_W-1:0] runs;
      logic [CNT_W-1:0]  cnt;
      logic [WORD_W-1:0] lacc;
      logic [WORD_W-1:0] dacc;
      logic [WORD_W-1:0] lword;
      logic [WORD_W-1:0] dword;
      logic [SIZE_W-1:0] next_cnt;
      logic [SIZE_W-1:0] hlen;
      logic [SIZE_W-1:0] hoff;
      logic [RUNS_W-1:0] limit;

      // A list start drops any partial run and restarts the list.
      ph   = phase_ff;
      base = base_ff;
      runs = runs_ff;
      cnt  = cnt_ff;
      lacc = len_acc_ff;
      dacc = delta_acc_ff;
      if (in_start_ff) begin
         ph   = PH_HEADER;
         base = '0;
         runs = '0;
         cnt  = '0;
         lacc = '0;
         dacc = '0;
      end

      // Insert the byte at the current position; for the offset, fill above it with the
      // sign of the byte, which is the top byte of the field when the run completes.
      for (int j = 0; j < BYTES_W; j++) begin
         lword[j*BYTE_W +: BYTE_W] = lacc[j*BYTE_W +: BYTE_W];
         dword[j*BYTE_W +: BYTE_W] = dacc[j*BYTE_W +: BYTE_W];
         if (j == int'(cnt)) begin
            lword[j*BYTE_W +: BYTE_W] = in_byte_ff;
            dword[j*BYTE_W +: BYTE_W] = in_byte_ff;
         end else if (j > int'(cnt)) begin
            dword[j*BYTE_W +: BYTE_W] = {BYTE_W{in_byte_ff[BYTE_W-1]}};
         end
      end

      next_cnt = {1'b0, cnt} + 4'd1;
      hlen     = in_byte_ff[SIZE_W-1:0];
      hoff     = in_byte_ff[BYTE_W-1:SIZE_W];
      limit    = (run_cap_ff < MAX_RUNS) ? run_cap_ff : MAX_RUNS;

      phase_in      = ph;
      len_size_in   = len_size_ff;
      off_size_in   = off_size_ff;
      cnt_in        = cnt;
      len_acc_in    = lacc;
      delta_acc_in  = dacc;
      base_in       = base;
      runs_in       = runs;
      emit          = 1'b0;
      out_status_in = ST_RUN;
      out_len_in    = '0;
      out_start_in  = '0;
      out_sparse_in = 1'b0;
      out_index_in  = runs;

      case (ph)
         PH_HEADER: begin
            len_size_in  = hlen;
            off_size_in  = hoff;
            cnt_in       = '0;
            len_acc_in   = '0;
            delta_acc_in = '0;
            if (hlen == '0 && hoff == '0) begin
               phase_in      = PH_IDLE;
               emit          = 1'b1;
               out_status_in = ST_END;
            end else if (hlen > MAX_FIELD_SIZE || hoff > MAX_FIELD_SIZE) begin
               phase_in      = PH_IDLE;
               emit          = 1'b1;
               out_status_in = ST_BAD_SIZE;
            end else if (runs >= limit) begin
               phase_in      = PH_IDLE;
               emit          = 1'b1;
               out_status_in = ST_TOO_MANY;
            end else begin
               phase_in = (hlen != '0) ? PH_LENGTH : PH_OFFSET;
            end
         end
         PH_LENGTH: begin
            len_acc_in = lword;
            cnt_in     = next_cnt[CNT_W-1:0];
            if (next_cnt >= len_size_ff) begin
               cnt_in = '0;
               if (off_size_ff == '0) begin
                  // Sparse run: the base is left as it is.
                  phase_in      = PH_HEADER;
                  len_acc_in    = '0;
                  runs_in       = runs + 11'd1;
                  emit          = 1'b1;
                  out_len_in    = lword;
                  out_sparse_in = 1'b1;
               end else begin
                  phase_in = PH_OFFSET;
               end
            end
         end
         PH_OFFSET: begin
            delta_acc_in = dword;
            cnt_in       = next_cnt[CNT_W-1:0];
            if (next_cnt >= off_size_ff) begin
               // Apply the signed delta to the running base.
               phase_in     = PH_HEADER;
               cnt_in       = '0;
               len_acc_in   = '0;
               delta_acc_in = '0;
               base_in      = base + dword;
               runs_in      = runs + 11'd1;
               emit         = 1'b1;
               out_len_in   = lacc;
               out_start_in = base + dword;
            end
         end
         PH_IDLE: begin
            phase_in = PH_IDLE;
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   always_comb begin
      out_vld_in = out_vld_ff && rsp_stall;
      if (proceed) begin
         out_vld_in = emit;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         run_cap_ff <= RUN_CAP_RESET;
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         phase_ff   <= PH_HEADER;
         cnt_ff     <= '0;
         runs_ff    <= '0;
      end else begin
         if (csr_wr_en) begin
            run_cap_ff <= csr_wr_data;
         end
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
         if (proceed) begin
            phase_ff <= phase_in;
            cnt_ff   <= cnt_in;
            runs_ff  <= runs_in;
         end
      end
   end

   // Accumulators and field sizes; reset clears them to match a fresh decoder.
   always_ff @(posedge clock) begin
      if (reset) begin
         len_size_ff  <= '0;
         off_size_ff  <= '0;
         len_acc_ff   <= '0;
         delta_acc_ff <= '0;
         base_ff      <= '0;
      end else if (proceed) begin
         len_size_ff  <= len_size_in;
         off_size_ff  <= off_size_in;
         len_acc_ff   <= len_acc_in;
         delta_acc_ff <= delta_acc_in;
         base_ff      <= base_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_byte_ff  <= req_data_byte;
         in_start_ff <= req_list_start;
      end
      if (proceed && emit) begin
         out_status_ff <= out_status_in;
         out_len_ff    <= out_len_in;
         out_start_ff  <= out_start_in;
         out_sparse_ff <= out_sparse_in;
         out_index_ff  <= out_index_in;
      end
   end

   assign rsp_valid      = out_vld_ff;
   assign rsp_status     = out_status_ff;
   assign rsp_run_length = out_len_ff;
   assign rsp_run_start  = out_start_ff;
   assign rsp_sparse     = out_sparse_ff;
   assign rsp_run_index  = out_index_ff;

`ifndef SYNTHESIS
   // Anything but a decoded run carries zero payload fields.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && out_status_ff != ST_RUN |->
         out_len_ff == '0 && out_start_ff == '0 && !out_sparse_ff)
      else $error("non-run result carries run fields");

   // A sparse run never reports a start cluster.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && out_sparse_ff |-> out_start_ff == '0)
      else $error("sparse run with nonzero start");

   // The run count never passes the hard limit.
   assert property (@(posedge clock) disable iff (reset)
      runs_ff <= MAX_RUNS)
      else $error("run count beyond limit");

   // With no byte held, a taken result leaves the result register empty.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !in_vld_ff |=> !rsp_valid)
      else $error("result repeated without a new byte");
`endif

endmodule

// ===== dv/run_list_decoder_tb_pkg.sv =====
`timescale 1ns / 100ps

package run_list_decoder_tb_pkg;
   import rld_pkg::*;

   // One decoded result as it leaves the block.
   typedef struct {
      status_type          status;
      logic [WORD_W-1:0]   run_length;
      logic [WORD_W-1:0]   run_start;
      logic                sparse;
      logic [RUNS_W-1:0]   run_index;
   } run_result_type;

   // Tracks the decoder state from the accepted bytes and checks each result
   // against the oldest one still owed.
   class run_decode_scoreboard;
      logic [RUNS_W-1:0] capacity;
      phase_type         phase;
      logic [SIZE_W-1:0] len_size;
      logic [SIZE_W-1:0] off_size;
      logic [SIZE_W-1:0] byte_cnt;
      logic [WORD_W-1:0] len_acc;
      logic [WORD_W-1:0] delta_acc;
      logic [WORD_W-1:0] cluster_base;
      int unsigned       runs;
      run_result_type    owed_q[$];
      int unsigned       mismatches;
      int unsigned       status_seen[4];

      function new();
         capacity = RUN_CAP_RESET;
         phase = PH_HEADER;
         len_size = '0;
         off_size = '0;
         cluster_base = '0;
         runs = 0;
         clear_fields();
         mismatches = 0;
         foreach (status_seen[i]) status_seen[i] = 0;
      endfunction

      function void set_capacity(logic [RUNS_W-1:0] value);
         capacity = value;
      endfunction

      function int unsigned pending();
         return owed_q.size();
      endfunction

      function void clear_fields();
         byte_cnt = '0;
         len_acc = '0;
         delta_acc = '0;
      endfunction

      function void owe(status_type st, logic [WORD_W-1:0] len, logic [WORD_W-1:0] first,
                        logic sp, int unsigned idx);
         run_result_type r;
         r.status = st;
         r.run_length = len;
         r.run_start = first;
         r.sparse = sp;
         r.run_index = idx[RUNS_W-1:0];
         owed_q.push_back(r);
      endfunction

      // A run is complete: apply the signed delta to the base unless sparse.
      function void close_run(logic is_sparse);
         logic [WORD_W-1:0] delta;
         logic [WORD_W-1:0] first;
         int unsigned       nbits;
         first = '0;
         if (!is_sparse) begin
            delta = delta_acc;
            nbits = BYTE_W * off_size;
            if (nbits < WORD_W && delta[nbits-1])
               delta = delta | ({WORD_W{1'b1}} << nbits);
            cluster_base = cluster_base + delta;
            first = cluster_base;
         end
         owe(ST_RUN, len_acc, first, is_sparse, runs);
         runs++;
         phase = PH_HEADER;
         clear_fields();
      endfunction

      // Called for every accepted byte. Returns 1 unless the decoder ignores it.
      function bit note_transfer(logic [BYTE_W-1:0] b, logic list_start);
         logic [RUNS_W-1:0] limit;
         if (list_start) begin
            cluster_base = '0;
            runs = 0;
            phase = PH_HEADER;
            clear_fields();
         end
         case (phase)
            PH_HEADER: begin
               len_size = b[3:0];
               off_size = b[7:4];
               clear_fields();
               limit = (capacity < MAX_RUNS) ? capacity : MAX_RUNS;
               if (len_size == 0 && off_size == 0) begin
                  phase = PH_IDLE;
                  owe(ST_END, '0, '0, 1'b0, runs);
               end else if (len_size > MAX_FIELD_SIZE || off_size > MAX_FIELD_SIZE) begin
                  phase = PH_IDLE;
                  owe(ST_BAD_SIZE, '0, '0, 1'b0, runs);
               end else if (runs >= limit) begin
                  phase = PH_IDLE;
                  owe(ST_TOO_MANY, '0, '0, 1'b0, runs);
               end else begin
                  phase = (len_size != 0) ? PH_LENGTH : PH_OFFSET;
               end
               return 1'b1;
            end
            PH_LENGTH: begin
               len_acc = len_acc | (WORD_W'(b) << ((BYTE_W * byte_cnt) & (WORD_W - 1)));
               byte_cnt++;
               if (byte_cnt >= len_size) begin
                  if (off_size == 0) begin
                     close_run(1'b1);
                  end else begin
                     byte_cnt = '0;
                     phase = PH_OFFSET;
                  end
               end
               return 1'b1;
            end
            PH_OFFSET: begin
               delta_acc = delta_acc | (WORD_W'(b) << ((BYTE_W * byte_cnt) & (WORD_W - 1)));
               byte_cnt++;
               if (byte_cnt >= off_size) close_run(1'b0);
               return 1'b1;
            end
            default: return 1'b0;
         endcase
      endfunction

      // Compares one accepted result with the oldest expectation.
      function void check_result(status_type st, logic [WORD_W-1:0] len,
                                 logic [WORD_W-1:0] first, logic sp,
                                 logic [RUNS_W-1:0] idx);
         run_result_type e;
         if (owed_q.size() == 0) begin
            $error("unexpected result: status %s, run_index %0d", st.name(), idx);
            mismatches++;
            return;
         end
         e = owed_q.pop_front();
         status_seen[e.status]++;
         if (st !== e.status) begin
            $error("status: expected %s, got %0d", e.status.name(), st);
            mismatches++;
         end
         if (len !== e.run_length) begin
            $error("run_length: expected %h, got %h", e.run_length, len);
            mismatches++;
         end
         if (first !== e.run_start) begin
            $error("run_start: expected %h, got %h", e.run_start, first);
            mismatches++;
         end
         if (sp !== e.sparse) begin
            $error("sparse: expected %0b, got %0b", e.sparse, sp);
            mismatches++;
         end
         if (idx !== e.run_index) begin
            $error("run_index: expected %0d, got %0d", e.run_index, idx);
            mismatches++;
         end
      endfunction
   endclass

endpackage

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
   import rld_pkg::*;
   import run_list_decoder_tb_pkg::*;

   localparam int unsigned CYCLE_LIMIT   = 200000;
   localparam int unsigned SEGMENT_BYTES = 220;
   localparam int unsigned HOLD_CYCLES   = 150;
   localparam int unsigned SETTLE_CYCLES = 6;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                csr_wr_en = 1'b0;
   logic [RUNS_W-1:0]   csr_wr_data = '0;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [BYTE_W-1:0]   req_data_byte = '0;
   logic                req_list_start = 1'b0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [1:0]          rsp_status;
   logic [WORD_W-1:0]   rsp_run_length;
   logic [WORD_W-1:0]   rsp_run_start;
   logic                rsp_sparse;
   logic [RUNS_W-1:0]   rsp_run_index;

   run_decode_scoreboard runs_sb = new();
   int unsigned          req_idle_pct = 0;
   int unsigned          rsp_idle_pct = 0;
   int unsigned          decoded_bytes = 0;
   int unsigned          cycle_count = 0;
   bit                   hold_arm = 1'b0;
   bit                   hold_taken = 1'b0;
   int unsigned          hold_left = 0;

   run_list_decoder_top u_dut (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data_byte  (req_data_byte),
      .req_list_start (req_list_start),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_run_length (rsp_run_length),
      .rsp_run_start  (rsp_run_start),
      .rsp_sparse     (rsp_sparse),
      .rsp_run_index  (rsp_run_index)
   );

   always #6 clock = ~clock;

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles.", cycle_count);
         $display("== FAIL ==");
         $finish;
      end
   end

   // Result side stall. A single long hold-off is counted here once armed.
   always @(negedge clock) begin
      if (hold_arm && !hold_taken) begin
         hold_left = HOLD_CYCLES;
         hold_taken = 1'b1;
      end
      if (hold_left > 0) begin
         rsp_stall = 1'b1;
         hold_left--;
      end else begin
         rsp_stall = ($urandom_range(99) < rsp_idle_pct);
      end
   end

   // Every result transfer is checked against the scoreboard.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         runs_sb.check_result(status_type'(rsp_status), rsp_run_length, rsp_run_start,
                              rsp_sparse, rsp_run_index);
   end

   function automatic logic [BYTE_W-1:0] field_byte();
      case ($urandom_range(7))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   // Offers one byte from a falling edge and returns at the falling edge after its transfer.
   task automatic send_byte(input logic [BYTE_W-1:0] b, input logic list_start);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data_byte = b;
      req_list_start = list_start;
      do @(posedge clock); while (req_stall);
      if (runs_sb.note_transfer(b, list_start)) decoded_bytes++;
      @(negedge clock);
   endtask

   // Waits until every owed result has come back and the pipeline is empty.
   task automatic settle();
      req_valid = 1'b0;
      while (runs_sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_capacity(input logic [RUNS_W-1:0] value);
      csr_wr_en = 1'b1;
      csr_wr_data = value;
      @(posedge clock);
      runs_sb.set_capacity(value);
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   // One run list with random field sizes and contents. A few lists carry a
   // bad header, stop in the middle of a run or lack the closing zero.
   task automatic play_list();
      int unsigned n_runs;
      int unsigned ls;
      int unsigned os;
      int unsigned roll;
      logic        fresh;
      n_runs = $urandom_range(1, 10);
      fresh = 1'b1;
      for (int i = 0; i < n_runs; i++) begin
         roll = $urandom_range(99);
         if (roll < 4) begin
            if ($urandom_range(1))
               send_byte({4'($urandom_range(15)), 4'($urandom_range(9, 15))}, fresh);
            else
               send_byte({4'($urandom_range(9, 15)), 4'($urandom_range(15))}, fresh);
            break;
         end
         ls = $urandom_range(8);
         os = $urandom_range(8);
         if (ls == 0 && os == 0) ls = 1;
         send_byte({os[3:0], ls[3:0]}, fresh);
         fresh = 1'b0;
         if (roll < 8) begin
            repeat ($urandom_range(ls + os - 1)) send_byte(field_byte(), 1'b0);
            return;
         end
         repeat (ls + os) send_byte(field_byte(), 1'b0);
      end
      if ($urandom_range(9) != 0) send_byte(8'h00, 1'b0);
      repeat ($urandom_range(3)) send_byte(field_byte(), 1'b0);
   endtask

   task automatic run_segment();
      int unsigned first;
      first = decoded_bytes;
      while (decoded_bytes - first < SEGMENT_BYTES) play_list();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part with room for two runs per list.
      write_capacity(11'd2);
      // Header before any list start, then a negative one-byte offset.
      send_byte(8'h11, 1'b0);
      send_byte(8'h05, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'h00, 1'b0);
      // Ignored after the end of a list.
      send_byte(8'h33, 1'b0);
      // Sparse run, then a run with no length field.
      send_byte(8'h01, 1'b1);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h10, 1'b0);
      send_byte(8'h7F, 1'b0);
      // Third run hits the limit; the next byte is ignored.
      send_byte(8'h01, 1'b0);
      send_byte(8'h02, 1'b0);
      // Oversized offset field, then oversized length field.
      send_byte(8'h92, 1'b1);
      send_byte(8'h29, 1'b1);
      // New list started in the middle of a run.
      send_byte(8'h22, 1'b1);
      send_byte(8'h01, 1'b0);
      send_byte(8'h00, 1'b1);
      settle();

      // No runs allowed: a bad size still wins over the run limit.
      write_capacity(11'd0);
      send_byte(8'hF1, 1'b1);
      send_byte(8'h11, 1'b1);
      settle();

      // Random lists, first with a small run limit and a slow receiver.
      req_idle_pct = 24;
      rsp_idle_pct = 48;
      write_capacity(11'($urandom_range(1, 6)));
      run_segment();
      settle();

      // Largest limit with a slow sender.
      req_idle_pct = 48;
      rsp_idle_pct = 24;
      write_capacity(MAX_RUNS);
      run_segment();
      settle();

      // Full rate, starting with a long receiver hold-off to back up the input.
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      write_capacity(11'($urandom_range(2, 12)));
      hold_arm = 1'b1;
      run_segment();
      settle();

      $display("Checked %0d decoded bytes: %0d runs, %0d list ends,", decoded_bytes,
               runs_sb.status_seen[ST_RUN], runs_sb.status_seen[ST_END]);
      $display("%0d size errors and %0d run-limit errors, under run limits 0 to 1024.",
               runs_sb.status_seen[ST_BAD_SIZE], runs_sb.status_seen[ST_TOO_MANY]);
      if (runs_sb.mismatches == 0 && runs_sb.pending() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/rld_pkg.sv
rtl/core/run_list_decoder_top.sv
dv/run_list_decoder_tb_pkg.sv
dv/testbench.sv
